FILE: hw/rtl/lkvc_pkg.sv
package lkvc_pkg;

	localparam int KEY_W        = 32;
	localparam int VAL_W        = 32;
	localparam int CAP_W        = 5;
	localparam int STATUS_W     = 3;
	localparam int MAX_ENTRIES_DEF = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_GET_HIT   = 3'd0,
		ST_GET_MISS  = 3'd1,
		ST_PUT_UPD   = 3'd2,
		ST_PUT_INS   = 3'd3,
		ST_PUT_EVICT = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_UPD
	} state_t;

	// Broadcast from the controller to every cell of the chain.
	typedef struct packed {
		logic clear;
		logic cmp_en;
		logic commit;
		logic touch;
		logic insert;
	} cell_ctrl_t;

endpackage

FILE: hw/rtl/lkvc_cell.sv
module lkvc_cell #(
	parameter int IDX   = 0,
	parameter int IDX_W = 4,
	parameter int OCC_W = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lkvc_pkg::cell_ctrl_t      ctrl,
	input  logic [IDX_W-1:0]          hit_pos,
	input  logic [OCC_W-1:0]          occ_lim,
	input  logic [lkvc_pkg::KEY_W-1:0] req_key,
	input  logic                      left_valid,
	input  logic [lkvc_pkg::KEY_W-1:0] left_key,
	input  logic [lkvc_pkg::VAL_W-1:0] left_value,
	output logic                      valid,
	output logic [lkvc_pkg::KEY_W-1:0] key,
	output logic [lkvc_pkg::VAL_W-1:0] value,
	output logic                      hit
);
	import lkvc_pkg::*;

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	logic             hit_q;
	logic             shift;

	// Cells up to the touched one move one place down the chain; an insert moves all.
	assign shift = ctrl.commit &&
		(ctrl.insert || (ctrl.touch && (IDX_W'(IDX) <= hit_pos)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				valid_q <= 1'b0;
			end else if (shift) begin
				// drop whatever falls past the new occupancy
				valid_q <= left_valid && (OCC_W'(IDX) < occ_lim);
			end
			if (ctrl.cmp_en) begin
				hit_q <= valid_q && (key_q == req_key);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q   <= left_key;
			value_q <= left_value;
		end
	end

	assign valid = valid_q;
	assign key   = key_q;
	assign value = value_q;
	assign hit   = hit_q;

endmodule

FILE: hw/rtl/lru_key_value_cache.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+-----------------------------------
// in       | in_valid / in_stall   | operation, key, value
// out      | out_valid / out_stall | status, read_value, evicted_key
// cfg      | cfg_valid / cfg_ready | capacity
//
// Entries sit in a chain of cells ordered by recency, most recent first.
// A request passes a compare state, where every cell is checked against the key,
// and an update state, which shifts the chain and loads the result register. The
// next request is taken in the update state, so it can overlap the commit.
// A stalled result holds the update state. Reset empties the chain and sets
// capacity to 16; a capacity write empties the chain too.
module lru_key_value_cache #(
	parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic signed [lkvc_pkg::KEY_W-1:0] key,
	input  logic signed [lkvc_pkg::VAL_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lkvc_pkg::STATUS_W-1:0]     status,
	output logic signed [lkvc_pkg::VAL_W-1:0] read_value,
	output logic signed [lkvc_pkg::KEY_W-1:0] evicted_key,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lkvc_pkg::CAP_W-1:0]        capacity
);
	import lkvc_pkg::*;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int OCC_W = $clog2(MAX_ENTRIES + 1);

	state_t           state_q, state_d;
	logic [CAP_W-1:0] cap_q;
	logic [OCC_W-1:0] occ_q, occ_new, eff_cap;

	logic             req_op_q;
	logic [KEY_W-1:0] req_key_q;
	logic [VAL_W-1:0] req_value_q;

	logic             out_valid_q;
	status_t          status_q, status_d;
	logic [VAL_W-1:0] read_value_q, rd_d;
	logic [KEY_W-1:0] evicted_key_q, ev_d;

	logic             in_acc, cfg_acc, out_free, commit;
	logic             hit_any, evict;
	logic [IDX_W-1:0] hit_pos;
	logic [VAL_W-1:0] hit_value, head_value;
	logic [KEY_W-1:0] last_key;
	cell_ctrl_t       ctrl;

	logic             cell_valid [MAX_ENTRIES];
	logic [KEY_W-1:0] cell_key   [MAX_ENTRIES];
	logic [VAL_W-1:0] cell_value [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] cell_hit;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == S_IDLE) || ((state_q == S_UPD) && out_free));
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = (state_q == S_IDLE);
	assign cfg_acc   = cfg_valid && cfg_ready;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = OCC_W'(1);
		end else if (32'(cap_q) > 32'(MAX_ENTRIES)) begin
			eff_cap = OCC_W'(MAX_ENTRIES);
		end else begin
			eff_cap = OCC_W'(cap_q);
		end
	end

	// Hit vector is one-hot or empty, so plain OR reductions select.
	always_comb begin
		hit_pos   = '0;
		hit_value = '0;
		last_key  = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (cell_hit[i]) begin
				hit_pos   = hit_pos | IDX_W'(i);
				hit_value = hit_value | cell_value[i];
			end
			if (OCC_W'(i + 1) == occ_q) begin
				last_key = last_key | cell_key[i];
			end
		end
	end

	assign hit_any    = |cell_hit;
	assign evict      = (req_op_q == OP_PUT) && !hit_any && (occ_q >= eff_cap)
		&& (occ_q != '0);
	assign head_value = (req_op_q == OP_PUT) ? req_value_q : hit_value;

	always_comb begin
		rd_d    = '0;
		ev_d    = '0;
		occ_new = occ_q;
		if (req_op_q == OP_GET) begin
			if (hit_any) begin
				status_d = ST_GET_HIT;
				rd_d     = hit_value;
			end else begin
				status_d = ST_GET_MISS;
			end
		end else if (hit_any) begin
			status_d = ST_PUT_UPD;
		end else if (evict) begin
			status_d = ST_PUT_EVICT;
			ev_d     = last_key;
		end else begin
			status_d = ST_PUT_INS;
			occ_new  = occ_q + OCC_W'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		commit  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				state_d = S_UPD;
			end
			S_UPD: begin
				if (out_free) begin
					commit  = 1'b1;
					state_d = in_acc ? S_CMP : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign ctrl.clear  = cfg_acc;
	assign ctrl.cmp_en = (state_q == S_CMP);
	assign ctrl.commit = commit;
	assign ctrl.touch  = hit_any;
	assign ctrl.insert = (req_op_q == OP_PUT) && !hit_any;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= CAP_RESET;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_acc) begin
				cap_q <= capacity;
				occ_q <= '0;
			end else if (commit) begin
				occ_q <= occ_new;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_op_q    <= operation;
			req_key_q   <= key;
			req_value_q <= value;
		end
		if (commit) begin
			status_q      <= status_d;
			read_value_q  <= rd_d;
			evicted_key_q <= ev_d;
		end
	end

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		logic             lv;
		logic [KEY_W-1:0] lk;
		logic [VAL_W-1:0] lval;

		if (g == 0) begin : g_head
			// new or touched entry enters at the head
			assign lv   = 1'b1;
			assign lk   = req_key_q;
			assign lval = head_value;
		end else begin : g_link
			assign lv   = cell_valid[g-1];
			assign lk   = cell_key[g-1];
			assign lval = cell_value[g-1];
		end

		lkvc_cell #(
			.IDX   (g),
			.IDX_W (IDX_W),
			.OCC_W (OCC_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.hit_pos    (hit_pos),
			.occ_lim    (occ_new),
			.req_key    (req_key_q),
			.left_valid (lv),
			.left_key   (lk),
			.left_value (lval),
			.valid      (cell_valid[g]),
			.key        (cell_key[g]),
			.value      (cell_value[g]),
			.hit        (cell_hit[g])
		);
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign evicted_key = evicted_key_q;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import lkvc_pkg::*;

	localparam int MAX_ENTRIES   = MAX_ENTRIES_DEF;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int LONG_HOLD     = 250;
	localparam int PHASE_ITEMS   = 155;
	localparam int RANDOM_PHASES = 8;

	typedef struct {
		logic                    op;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} cache_request_t;

	typedef struct {
		status_t                 status;
		logic signed [VAL_W-1:0] read_value;
		logic signed [KEY_W-1:0] evicted_key;
	} cache_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    operation = OP_GET;
	logic signed [KEY_W-1:0] req_key = '0;
	logic signed [VAL_W-1:0] req_value = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [STATUS_W-1:0]     out_status;
	logic signed [VAL_W-1:0] out_read_value;
	logic signed [KEY_W-1:0] out_evicted_key;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CAP_W-1:0]        cfg_capacity = CAP_RESET;

	// Shadow copy of the cache, indexed by slot; age 0 is the most recent entry
	logic                    cache_valid [MAX_ENTRIES];
	logic [KEY_W-1:0]        cache_key   [MAX_ENTRIES];
	logic [VAL_W-1:0]        cache_val   [MAX_ENTRIES];
	int                      cache_age   [MAX_ENTRIES];
	int                      cache_fill;
	logic [CAP_W-1:0]        cap_setting = CAP_RESET;

	cache_request_t pending_requests [$];
	cache_reply_t   expected_replies [$];
	cache_reply_t   accepted_reply;
	cache_reply_t   head_reply;

	int  gap_left;
	int  stall_left;
	int  stall_roll;
	bit  send_next;
	bit  burst_mode;
	bit  hold_request;
	bit  cfg_busy;
	logic [CAP_W-1:0] cfg_word;

	int  cycle_count;
	int  mismatches;
	int  requests_sent;
	int  replies_checked;
	int  cap_writes;
	int  hit_count;
	int  miss_count;
	int  update_count;
	int  insert_count;
	int  evict_count;

	logic [CAP_W-1:0] phase_caps [RANDOM_PHASES];

	lru_key_value_cache DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.key        (req_key),
		.value      (req_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (out_status),
		.read_value (out_read_value),
		.evicted_key(out_evicted_key),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.capacity   (cfg_capacity)
	);

	always #5 clk = ~clk;

	function automatic int eff_capacity(logic [CAP_W-1:0] c);
		if (c == 0)
			return 1;
		if (c > MAX_ENTRIES)
			return MAX_ENTRIES;
		return int'(c);
	endfunction

	function automatic void clear_cache();
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			cache_valid[i] = 1'b0;
			cache_key[i]   = '0;
			cache_val[i]   = '0;
			cache_age[i]   = 0;
		end
		cache_fill = 0;
	endfunction

	// Age every entry newer than the slot, then make the slot the newest
	function automatic void promote_slot(int s);
		int r;
		r = cache_age[s];
		for (int i = 0; i < MAX_ENTRIES; i++)
			if (cache_valid[i] && cache_age[i] < r)
				cache_age[i]++;
		cache_age[s] = 0;
	endfunction

	function automatic cache_reply_t predict_access(logic op, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		cache_reply_t r;
		int hit_slot;
		int lru_slot;
		int free_slot;
		r.status      = ST_GET_MISS;
		r.read_value  = '0;
		r.evicted_key = '0;
		hit_slot  = -1;
		lru_slot  = -1;
		free_slot = -1;
		for (int i = 0; i < MAX_ENTRIES; i++)
			if (hit_slot < 0 && cache_valid[i] && cache_key[i] == k)
				hit_slot = i;
		if (op == OP_GET) begin
			if (hit_slot >= 0) begin
				r.read_value = cache_val[hit_slot];
				promote_slot(hit_slot);
				r.status = ST_GET_HIT;
			end
		end else if (hit_slot >= 0) begin
			cache_val[hit_slot] = v;
			promote_slot(hit_slot);
			r.status = ST_PUT_UPD;
		end else begin
			r.status = ST_PUT_INS;
			if (cache_fill >= eff_capacity(cap_setting)) begin
				for (int i = 0; i < MAX_ENTRIES; i++)
					if (cache_valid[i] && (lru_slot < 0 || cache_age[i] > cache_age[lru_slot]))
						lru_slot = i;
				if (lru_slot >= 0) begin
					r.evicted_key = cache_key[lru_slot];
					cache_valid[lru_slot] = 1'b0;
					cache_fill--;
					r.status = ST_PUT_EVICT;
				end
			end
			for (int i = 0; i < MAX_ENTRIES; i++)
				if (free_slot < 0 && !cache_valid[i])
					free_slot = i;
			if (free_slot >= 0) begin
				for (int i = 0; i < MAX_ENTRIES; i++)
					if (cache_valid[i])
						cache_age[i]++;
				cache_valid[free_slot] = 1'b1;
				cache_key[free_slot]   = k;
				cache_val[free_slot]   = v;
				cache_age[free_slot]   = 0;
				cache_fill++;
			end
		end
		return r;
	endfunction

	function automatic int draw_gap();
		int roll;
		if (burst_mode)
			return 0;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic logic [31:0] draw_word();
		int roll;
		roll = $urandom_range(99);
		if (roll < 3)
			return 32'h8000_0000;
		if (roll < 6)
			return 32'h7FFF_FFFF;
		if (roll < 8)
			return 32'h0000_0000;
		if (roll < 10)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	task automatic add_request(logic op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		cache_request_t item;
		item.op    = op;
		item.key   = k;
		item.value = v;
		pending_requests.push_back(item);
	endtask

	// Mostly gets and puts on a key set larger than the capacity,
	// so that hits, updates and evictions all come up; the rest are stray keys
	task automatic fill_random_phase(int count);
		logic [KEY_W-1:0] key_pool [$];
		int pool_size;
		int limit;
		logic [KEY_W-1:0] k;
		limit = eff_capacity(cap_setting);
		pool_size = limit + $urandom_range(1, limit + 2);
		for (int i = 0; i < pool_size; i++)
			key_pool.push_back(draw_word());
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 85)
				k = key_pool[$urandom_range(pool_size - 1)];
			else
				k = $urandom;
			add_request($urandom_range(1) ? OP_PUT : OP_GET, k, draw_word());
		end
	endtask

	// Let the block drain and settle before touching the register
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_replies.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] c);
		cfg_word = c;
		cfg_busy = 1'b1;
		do
			@(negedge clk);
		while (cfg_busy);
		cap_writes++;
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			operation <= OP_GET;
			req_key   <= '0;
			req_value <= '0;
			gap_left = 0;
		end else begin
			send_next = 1'b0;
			if (in_valid && !in_stall) begin
				accepted_reply = predict_access(operation, req_key, req_value);
				expected_replies.push_back(accepted_reply);
				requests_sent++;
				void'(pending_requests.pop_front());
				gap_left = draw_gap();
				send_next = (gap_left == 0);
			end else if (!in_valid) begin
				if (gap_left > 0)
					gap_left--;
				send_next = (gap_left == 0);
			end
			if (in_valid && in_stall) begin
				// hold the stalled request
			end else if (send_next && pending_requests.size() != 0) begin
				in_valid  <= 1'b1;
				operation <= pending_requests[0].op;
				req_key   <= pending_requests[0].key;
				req_value <= pending_requests[0].value;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output stall generator, including the one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (burst_mode) begin
				out_stall <= 1'b0;
			end else begin
				stall_roll = $urandom_range(99);
				if (stall_roll < 65) begin
					out_stall <= 1'b0;
				end else begin
					stall_left = (stall_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
					out_stall <= 1'b1;
				end
			end
		end
	end

	// Reply monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
		end else if (out_valid && !out_stall) begin
			if (expected_replies.size() == 0) begin
				$error("unexpected reply: status %0d read_value %0d evicted_key %0d",
					out_status, out_read_value, out_evicted_key);
				mismatches++;
			end else begin
				head_reply = expected_replies.pop_front();
				replies_checked++;
				case (head_reply.status)
					ST_GET_HIT:   hit_count++;
					ST_GET_MISS:  miss_count++;
					ST_PUT_UPD:   update_count++;
					ST_PUT_INS:   insert_count++;
					ST_PUT_EVICT: evict_count++;
					default: ;
				endcase
				if (out_status !== head_reply.status) begin
					$error("status: expected %0d, got %0d", head_reply.status, out_status);
					mismatches++;
				end
				if (out_read_value !== head_reply.read_value) begin
					$error("read_value: expected %0d, got %0d",
						head_reply.read_value, out_read_value);
					mismatches++;
				end
				if (out_evicted_key !== head_reply.evicted_key) begin
					$error("evicted_key: expected %0d, got %0d",
						head_reply.evicted_key, out_evicted_key);
					mismatches++;
				end
			end
		end
	end

	// Capacity register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid    <= 1'b0;
			cfg_capacity <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_setting = cfg_capacity;
			clear_cache();
			cfg_valid <= 1'b0;
			cfg_busy = 1'b0;
		end else if (!cfg_valid && cfg_busy) begin
			cfg_valid    <= 1'b1;
			cfg_capacity <= cfg_word;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d replies still outstanding",
				cycle_count, expected_replies.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		clear_cache();
		phase_caps = '{5'd31, 5'd1, 5'd16, 5'd17, 5'd0, 5'd8, 5'd3, 5'd9};
		phase_caps[6] = CAP_W'($urandom_range(3, 15));
		phase_caps[7] = CAP_W'($urandom_range(0, 31));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset capacity: miss, inserts at the key and value extremes, hits, update
		add_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
		add_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		add_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		add_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
		add_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
		add_request(OP_PUT, 32'h7FFF_FFFF, 32'h0000_0001);
		add_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		add_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
		add_request(OP_GET, 32'd12345, 32'hFFFF_FFFF);

		// Zero capacity acts as one; the write also empties the store
		wait_idle();
		set_capacity(5'd0);
		add_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		add_request(OP_PUT, 32'd5, 32'd50);
		add_request(OP_PUT, 32'd6, 32'd60);
		add_request(OP_GET, 32'd5, 32'h0000_0000);
		add_request(OP_GET, 32'd6, 32'h0000_0000);
		add_request(OP_PUT, 32'd6, 32'd61);

		// A get refreshes recency, so the other entry goes first
		wait_idle();
		set_capacity(5'd2);
		add_request(OP_PUT, 32'd1, 32'd10);
		add_request(OP_PUT, 32'd2, 32'd20);
		add_request(OP_GET, 32'd1, 32'h0000_0000);
		add_request(OP_PUT, 32'd3, 32'd30);
		add_request(OP_GET, 32'd2, 32'h0000_0000);
		add_request(OP_GET, 32'd1, 32'h0000_0000);
		add_request(OP_PUT, 32'd4, 32'd40);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_idle();
			set_capacity(phase_caps[p]);
			burst_mode = (p == 2);
			fill_random_phase(PHASE_ITEMS);
			if (p == 3)
				hold_request = 1'b1;
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (expected_replies.size() != 0) begin
			$error("%0d expected replies never arrived", expected_replies.size());
			mismatches++;
		end
		$display("Covered %0d requests over %0d capacity settings, %0d replies checked",
			requests_sent, cap_writes + 1, replies_checked);
		$display("Hits %0d, misses %0d, updates %0d, inserts %0d, evictions %0d",
			hit_count, miss_count, update_count, insert_count, evict_count);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
